// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SYNC(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ASSERT_SYNC(lbl, clock, reset, prop, msg)

`define ASSERT_ALWAYS(lbl, clock, prop, msg)

`endif

`endif

// File: rtl/mswq_pkg.sv
// Shared types and constants for the mode-switched deque stack.
`timescale 1ns / 1ps
`default_nettype none

package mswq_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int CELL_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int OFFSET_W = 10;
  localparam int COUNT_W  = 11;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [0:0] REG_QUEUE_MODE  = 1'b0;
  localparam logic [0:0] REG_INVERT_MODE = 1'b1;

  typedef struct packed {
    logic               overflow;
    logic               is_empty;
    logic [COUNT_W-1:0] element_count;
    logic [VALUE_W-1:0] read_value;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/mswq_ram.sv
// Cell RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mswq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mswq_ctrl.sv
// Pointer, count and mode control with the result register.
`timescale 1ns / 1ps
`default_nettype none

module mswq_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int CELL_WIDTH = 32,
  parameter int AW         = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic                              cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [mswq_pkg::OP_W-1:0]         op,
  input  wire logic signed [mswq_pkg::VALUE_W-1:0] push_value,
  input  wire logic [mswq_pkg::OFFSET_W-1:0]     peek_offset,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mswq_pkg::result_t                      res,
  output logic                                   mem_we,
  output logic [AW-1:0]                          mem_waddr,
  output logic [CELL_WIDTH-1:0]                  mem_wdata,
  output logic                                   mem_re,
  output logic [AW-1:0]                          mem_raddr,
  input  wire logic [CELL_WIDTH-1:0]             mem_rdata
);

  import mswq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + OFFSET_W;
  localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL   = CW'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic          state, state_next;
  logic [AW-1:0] top, top_next;
  logic [AW-1:0] bottom, bottom_next;
  logic [CW-1:0] count, count_next;
  logic          queue_mode, invert_mode;

  logic          out_free, accept, load, load_rd;
  result_t       res_next;

  logic [AW-1:0] top_inc, top_dec, bot_inc, bot_dec, ofs_a;
  logic [AW:0]   peek_sum, peek_idx;

  always_comb begin
    top_inc = (top == LAST) ? '0 : top + 1'b1;
    top_dec = (top == '0) ? LAST : top - 1'b1;
    bot_inc = (bottom == LAST) ? '0 : bottom + 1'b1;
    bot_dec = (bottom == '0) ? LAST : bottom - 1'b1;
    ofs_a   = AW'(peek_offset);
    if (queue_mode) begin
      peek_sum = (AW + 1)'(bottom) + (AW + 1)'(ofs_a);
    end else begin
      peek_sum = (AW + 1)'(top) + ((AW + 1)'(LAST) - (AW + 1)'(ofs_a));
    end
    peek_idx = (peek_sum >= DEPTH_X) ? peek_sum - DEPTH_X : peek_sum;
  end

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    top_next    = top;
    bottom_next = bottom;
    count_next  = count;
    mem_we      = 1'b0;
    mem_waddr   = top;
    mem_wdata   = CELL_WIDTH'(push_value);
    mem_re      = 1'b0;
    mem_raddr   = top_dec;
    load        = 1'b0;
    load_rd     = 1'b0;
    res_next.overflow = 1'b0;
    if (accept) begin
      load = 1'b1;
      case (op)
        OP_PUSH: begin
          if (count == FULL) begin
            res_next.overflow = 1'b1;
          end else if (invert_mode) begin
            mem_we      = 1'b1;
            mem_waddr   = bot_dec;
            bottom_next = bot_dec;
            count_next  = count + 1'b1;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = top;
            top_next   = top_inc;
            count_next = count + 1'b1;
          end
        end
        OP_POP: begin
          if (count != '0) begin
            load       = 1'b0;
            mem_re     = 1'b1;
            state_next = ST_READ;
            count_next = count - 1'b1;
            if (queue_mode) begin
              mem_raddr   = bottom;
              bottom_next = bot_inc;
            end else begin
              mem_raddr = top_dec;
              top_next  = top_dec;
            end
          end
        end
        OP_PEEK: begin
          if (PW'(peek_offset) < PW'(count)) begin
            load       = 1'b0;
            mem_re     = 1'b1;
            mem_raddr  = peek_idx[AW-1:0];
            state_next = ST_READ;
          end
        end
        default: begin
        end
      endcase
    end else if (state == ST_READ && out_free) begin
      load_rd    = 1'b1;
      state_next = ST_IDLE;
    end
    res_next.read_value    = load_rd ? VALUE_W'(signed'(mem_rdata)) : '0;
    res_next.element_count = COUNT_W'(count_next);
    res_next.is_empty      = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      top         <= '0;
      bottom      <= '0;
      count       <= '0;
      queue_mode  <= 1'b0;
      invert_mode <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      top    <= top_next;
      bottom <= bottom_next;
      count  <= count_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_QUEUE_MODE:  queue_mode  <= cfg_data;
          REG_INVERT_MODE: invert_mode <= cfg_data;
          default: begin
          end
        endcase
      end
      if (load || load_rd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load || load_rd) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mode_switched_deque_stack_top.sv
// Mode-switched deque stack: stream ports, control and cell RAM.
// A push, or a pop/peek that reads no cell, shows its result in the cycle after
// the item is accepted; one that reads a cell reads the RAM's registered read data,
// then loads the result register once the output is free. Pushes are taken 1 item
// per cycle while the output is not stalled; a cell read holds off new items until done.
// Reset clears pointers, count and mode registers; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mode_switched_deque_stack_top #(
  parameter int DEPTH      = mswq_pkg::DEPTH_DEF,
  parameter int CELL_WIDTH = mswq_pkg::CELL_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [0:0]                          cfg_index,
  input  wire logic                                cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // push_value[31:0], peek_offset[41:32], zero pad
  input  wire logic [mswq_pkg::IN_DATA_W-1:0]      s_tdata,
  // op[1:0]
  input  wire logic [mswq_pkg::OP_W-1:0]           s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // read_value[31:0], element_count[42:32], is_empty[43], overflow[44], zero pad
  output logic [mswq_pkg::OUT_DATA_W-1:0]          m_tdata
);

  import mswq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [CELL_WIDTH-1:0] mem_wdata, mem_rdata;
  result_t               res;

  mswq_ctrl #(
    .DEPTH      (DEPTH),
    .CELL_WIDTH (CELL_WIDTH),
    .AW         (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .op          (s_tuser),
    .push_value  (signed'(s_tdata[VALUE_W-1:0])),
    .peek_offset (s_tdata[VALUE_W+OFFSET_W-1:VALUE_W]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  mswq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (CELL_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign m_tdata = OUT_DATA_W'(res);

  `ASSERT_ALWAYS(a_rst_clears_out, clk, rst |=> !m_tvalid, "result valid after reset")
  `ASSERT_SYNC(a_count_bound, clk, rst, m_tvalid |-> (32'(res.element_count) <= 32'(DEPTH)), "count above depth")
  `ASSERT_SYNC(a_empty_flag, clk, rst, m_tvalid |-> (res.is_empty == (res.element_count == '0)), "empty flag mismatch")
  `ASSERT_SYNC(a_ovf_full, clk, rst, (m_tvalid && res.overflow) |-> (32'(res.element_count) == 32'(DEPTH)), "overflow while not full")

endmodule

`default_nettype wire

// File: dv/mode_switched_deque_stack_top_tb.sv
// Self-checking testbench for the mode-switched deque stack.
`timescale 1ns / 1ps

module mode_switched_deque_stack_top_tb;
  import mswq_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 250;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] STORE_FULL = COUNT_W'(STORE_DEPTH);

  typedef struct {
    bit                  is_cfg;
    logic [0:0]          reg_idx;
    logic                reg_val;
    logic [OP_W-1:0]     op;
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] offset;
    bit                  typed;
    result_t             want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [0:0]            cfg_index;
  logic                  cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Stack image kept alongside the block.
  logic [VALUE_W-1:0]  ring_cells [STORE_DEPTH];
  logic [OFFSET_W-1:0] ring_top = '0;
  logic [OFFSET_W-1:0] ring_bottom = '0;
  logic [COUNT_W-1:0]  cells_held = '0;
  logic                mode_queue = 1'b0;
  logic                mode_invert = 1'b0;

  result_t pending_results[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      results_checked = 0;
  int      dropped_pushes = 0;
  int      peak_fill = 0;
  int      cycle_count = 0;
  bit      gaps_on = 1'b1;
  bit      stalls_on = 1'b1;
  bit      hold_pending = 1'b0;

  mode_switched_deque_stack_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic result_t stack_op_result(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                              logic [OFFSET_W-1:0] offset);
    result_t r;
    logic [OFFSET_W-1:0] idx;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (cells_held == STORE_FULL) begin
          r.overflow = 1'b1;
          dropped_pushes++;
        end else if (mode_invert) begin
          ring_bottom = ring_bottom - 1'b1;
          ring_cells[ring_bottom] = value;
          cells_held++;
        end else begin
          ring_cells[ring_top] = value;
          ring_top = ring_top + 1'b1;
          cells_held++;
        end
      end
      OP_POP: begin
        if (cells_held != '0) begin
          if (mode_queue) begin
            r.read_value = ring_cells[ring_bottom];
            ring_bottom = ring_bottom + 1'b1;
          end else begin
            ring_top = ring_top - 1'b1;
            r.read_value = ring_cells[ring_top];
          end
          cells_held--;
        end
      end
      OP_PEEK: begin
        if ({1'b0, offset} < cells_held) begin
          idx = mode_queue ? ring_bottom + offset : ring_top - 1'b1 - offset;
          r.read_value = ring_cells[idx];
        end
      end
      default: ;
    endcase
    r.element_count = cells_held;
    r.is_empty = (cells_held == '0);
    if (int'(cells_held) > peak_fill) peak_fill = int'(cells_held);
    return r;
  endfunction

  function automatic step_t op_row(logic [OP_W-1:0] op, logic [VALUE_W-1:0] v,
                                   logic [OFFSET_W-1:0] ofs);
    step_t s;
    s = '{default: '0};
    s.op = op;
    s.value = v;
    s.offset = ofs;
    return s;
  endfunction

  function automatic step_t known_row(logic [OP_W-1:0] op, logic [VALUE_W-1:0] v,
                                      logic [OFFSET_W-1:0] ofs, logic [VALUE_W-1:0] rv,
                                      logic [COUNT_W-1:0] count);
    step_t s;
    s = op_row(op, v, ofs);
    s.typed = 1'b1;
    s.want.read_value = rv;
    s.want.element_count = count;
    s.want.is_empty = (count == '0);
    s.want.overflow = 1'b0;
    return s;
  endfunction

  function automatic step_t reg_row(logic [0:0] idx, logic val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic void note_error(string what, logic [VALUE_W-1:0] want,
                                     logic [VALUE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  task automatic send_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                         logic [OFFSET_W-1:0] offset, bit typed, result_t want);
    result_t calc;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_DATA_W-OFFSET_W-VALUE_W){1'b0}}, offset, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    calc = stack_op_result(op, value, offset);
    pending_results.push_back(typed ? want : calc);
    items_sent++;
  endtask

  task automatic send_random(int push_pct);
    logic [OP_W-1:0]     op;
    logic [VALUE_W-1:0]  v;
    logic [OFFSET_W-1:0] ofs;
    int                  pick;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) op = OP_PUSH;
    else if (pick < push_pct + (100 - push_pct) / 2) op = OP_POP;
    else op = OP_PEEK;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = '0;
      3: v = '1;
      default: v = $urandom();
    endcase
    // mostly in range; the rest lands anywhere, often past the fill
    if (cells_held != '0 && $urandom_range(0, 3) != 0)
      ofs = OFFSET_W'($urandom_range(0, cells_held - 1));
    else ofs = OFFSET_W'($urandom_range(0, 1023));
    send_op(op, v, ofs, 1'b0, '0);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_QUEUE_MODE) mode_queue = val;
    else mode_invert = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_modes(logic queue_on, logic invert_on);
    settle();
    write_reg(REG_QUEUE_MODE, queue_on);
    write_reg(REG_INVERT_MODE, invert_on);
  endtask

  // Result sink: random stalls, plus one long hold-off on request.
  initial begin : sink
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        note_error("unexpected item", '0, got.read_value);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.read_value !== want.read_value)
          note_error("read_value", want.read_value, got.read_value);
        if (got.element_count !== want.element_count)
          note_error("element_count", VALUE_W'(want.element_count),
                     VALUE_W'(got.element_count));
        if (got.is_empty !== want.is_empty)
          note_error("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
        if (got.overflow !== want.overflow)
          note_error("overflow", VALUE_W'(want.overflow), VALUE_W'(got.overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    step_t plan[$];
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, extremes, every op, mode switches, last-cell queue pop
    plan.push_back(known_row(OP_POP, 32'h0, 10'd0, 32'h0, 11'd0));
    plan.push_back(known_row(OP_PEEK, 32'h0, 10'd0, 32'h0, 11'd0));
    plan.push_back(known_row(OP_UNUSED, 32'hffff_ffff, 10'd1023, 32'h0, 11'd0));
    plan.push_back(known_row(OP_PUSH, 32'h7fff_ffff, 10'd0, 32'h0, 11'd1));
    plan.push_back(known_row(OP_PUSH, 32'h8000_0000, 10'd1023, 32'h0, 11'd2));
    plan.push_back(known_row(OP_PUSH, 32'hffff_ffff, 10'd0, 32'h0, 11'd3));
    plan.push_back(known_row(OP_PUSH, 32'h0, 10'd0, 32'h0, 11'd4));
    plan.push_back(op_row(OP_PEEK, 32'h0, 10'd0));
    plan.push_back(op_row(OP_PEEK, 32'h0, 10'd3));
    plan.push_back(known_row(OP_PEEK, 32'h0, 10'd4, 32'h0, 11'd4));
    plan.push_back(known_row(OP_PEEK, 32'hffff_ffff, 10'd1023, 32'h0, 11'd4));
    plan.push_back(known_row(OP_UNUSED, 32'h0, 10'd0, 32'h0, 11'd4));
    plan.push_back(op_row(OP_POP, 32'h0, 10'd0));
    plan.push_back(reg_row(REG_QUEUE_MODE, 1'b1));
    plan.push_back(op_row(OP_PEEK, 32'h0, 10'd0));
    plan.push_back(op_row(OP_POP, 32'h0, 10'd0));
    plan.push_back(reg_row(REG_INVERT_MODE, 1'b1));
    plan.push_back(op_row(OP_PUSH, 32'h1234_5678, 10'd0));
    plan.push_back(op_row(OP_PEEK, 32'h0, 10'd0));
    plan.push_back(op_row(OP_POP, 32'h0, 10'd0));
    plan.push_back(reg_row(REG_QUEUE_MODE, 1'b0));
    plan.push_back(op_row(OP_POP, 32'h0, 10'd0));
    plan.push_back(reg_row(REG_QUEUE_MODE, 1'b1));
    plan.push_back(known_row(OP_POP, 32'h0, 10'd0, 32'h8000_0000, 11'd0));
    plan.push_back(known_row(OP_POP, 32'h0, 10'd0, 32'h0, 11'd0));
    plan.push_back(known_row(OP_PEEK, 32'h0, 10'd0, 32'h0, 11'd0));

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        settle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        send_op(plan[k].op, plan[k].value, plan[k].offset, plan[k].typed, plan[k].want);
      end
    end

    // mixed traffic under each mode pair
    set_modes(1'b0, 1'b0);
    repeat (100) send_random(50);
    set_modes(1'b1, 1'b0);
    repeat (100) send_random(50);
    set_modes(1'b0, 1'b1);
    stalls_on = 1'b0;
    repeat (100) send_random(55);
    set_modes(1'b1, 1'b1);
    stalls_on = 1'b1;
    gaps_on = 1'b0;
    repeat (100) send_random(50);

    // fill to capacity with the sink held off at first, then hammer a full store
    set_modes(1'b0, 1'b0);
    gaps_on = 1'b1;
    hold_pending = 1'b1;
    while (cells_held < STORE_FULL) send_random(95);
    repeat (40) send_random(90);

    // drain with no idling on either side
    set_modes(1'b1, 1'b1);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (150) send_random(20);

    settle();
    repeat (10) @(posedge clk);
    $display("run covered %0d items over all four mode settings, %0d results checked",
             items_sent, results_checked);
    $display("store peaked at %0d cells, %0d pushes dropped when full, %0d mismatches",
             peak_fill, dropped_pushes, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
